// ----- rtl/gbi_pkg.sv -----
// ---------------------------------------------------------------------------
// gbi_pkg
// Shared types and constants for the bilinear grid lookup block.
// ---------------------------------------------------------------------------
package gbi_pkg;

    localparam int COORD_W   = 32;
    localparam int IN_IDX_W  = 6;
    localparam int GRID_N_W  = 7;
    localparam int CFG_IDX_W = 3;

    typedef enum logic {
        FUNC_WRITE = 1'b0,
        FUNC_QUERY = 1'b1
    } func_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_X_ORIGIN = 3'd0,
        CFG_Y_ORIGIN = 3'd1,
        CFG_X_SCALE  = 3'd2,
        CFG_Y_SCALE  = 3'd3,
        CFG_GRID_COLS = 3'd4,
        CFG_GRID_ROWS = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } axis_en_t;

    typedef struct packed {
        func_t                func;
        logic [IN_IDX_W-1:0]  row;
        logic [IN_IDX_W-1:0]  col;
        logic [COORD_W-1:0]   value;
    } wr_item_t;

endpackage

// ----- rtl/gbi_ram.sv -----
// ---------------------------------------------------------------------------
// gbi_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ---------------------------------------------------------------------------
module gbi_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- rtl/gbi_axis.sv -----
// ---------------------------------------------------------------------------
// gbi_axis
// Maps one query coordinate to a grid index and fraction over three stages:
// origin subtract, scale multiply, then clamp and split.
// ---------------------------------------------------------------------------
module gbi_axis #(
    parameter int MAX_N     = 64,
    parameter int FRAC_BITS = 16
) (
    input  logic                                 aclk,
    input  gbi_pkg::axis_en_t                    en,
    input  logic signed [gbi_pkg::COORD_W-1:0]   coord,
    input  logic signed [gbi_pkg::COORD_W-1:0]   origin,
    input  logic        [gbi_pkg::COORD_W-1:0]   scale,
    input  logic        [gbi_pkg::GRID_N_W-1:0]  size,
    output logic        [$clog2(MAX_N)-1:0]      idx,
    output logic        [FRAC_BITS:0]            frac
);

    import gbi_pkg::*;

    localparam int IW        = $clog2(MAX_N);
    localparam int POS_SHIFT = COORD_W - FRAC_BITS;
    localparam int PW        = 2 * COORD_W - POS_SHIFT;
    localparam logic [FRAC_BITS:0] FRAC_ONE = (FRAC_BITS + 1)'(1) << FRAC_BITS;

    logic signed [COORD_W:0]     d_reg;
    logic signed [COORD_W:0]     d_next;
    logic [2*COORD_W-1:0]        prod_reg;
    logic [2*COORD_W-1:0]        prod_next;
    logic [IW-1:0]               idx_reg;
    logic [IW-1:0]               idx_next;
    logic [FRAC_BITS:0]          frac_reg;
    logic [FRAC_BITS:0]          frac_next;
    logic [COORD_W-1:0]          d_lo;
    logic [PW-1:0]               pos;
    logic [PW-1:0]               limit;
    logic [31:0]                 n32;
    logic [31:0]                 size32;

    assign d_next = {coord[COORD_W-1], coord} - {origin[COORD_W-1], origin};
    assign d_lo   = d_reg[COORD_W-1:0];

    always_comb begin
        if (!d_reg[COORD_W] && (d_reg != '0)) begin
            prod_next = d_lo * scale;
        end else begin
            prod_next = '0;
        end
    end

    assign size32 = 32'(size);

    always_comb begin
        if (size32 < 32'd2) begin
            n32 = 32'd2;
        end else if (size32 > 32'(MAX_N)) begin
            n32 = 32'(MAX_N);
        end else begin
            n32 = size32;
        end
    end

    assign pos   = prod_reg[2*COORD_W-1:POS_SHIFT];
    assign limit = PW'(n32 - 32'd1) << FRAC_BITS;

    always_comb begin
        if (pos >= limit) begin
            idx_next  = IW'(n32 - 32'd2);
            frac_next = FRAC_ONE;
        end else begin
            idx_next  = pos[FRAC_BITS+IW-1:FRAC_BITS];
            frac_next = {1'b0, pos[FRAC_BITS-1:0]};
        end
    end

    always_ff @(posedge aclk) begin
        if (en.s1) begin
            d_reg <= d_next;
        end
        if (en.s2) begin
            prod_reg <= prod_next;
        end
        if (en.s3) begin
            idx_reg  <= idx_next;
            frac_reg <= frac_next;
        end
    end

    assign idx  = idx_reg;
    assign frac = frac_reg;

endmodule

// ----- rtl/grid_bilinear_interp.sv -----
// ---------------------------------------------------------------------------
// grid_bilinear_interp
// Bilinear lookup in a uniform two-dimensional grid of fixed-point samples.
// ---------------------------------------------------------------------------
// The input stream carries two kinds of beats, chosen by s_tuser. A write
// beat stores entry_value at row_index, col_index; it gives no result. A
// query beat maps x_coord and y_coord onto the grid and returns one
// interpolated sample on the master stream. Results leave in input order.
// The user must write configuration through the cfg channel only while the
// block is idle; the block does not enforce this. cfg_ready is always high.
// A query result reaches m_tvalid through the pipeline stages and the output
// register. One beat is accepted every cycle while s_tready is high: the
// grid sits in four RAM banks split by row and column parity, so the four
// neighbours of a point are read in the same cycle, and a write uses the
// same RAM stage as a read; stores and lookups keep order without forwarding.
// Reset restores the configuration defaults and empties the pipeline; the
// grid contents are not cleared and no clearing pass runs. When m_tready is
// low, pipeline bubbles close up first, and s_tready drops only once every
// stage holds a beat.
// ---------------------------------------------------------------------------
module grid_bilinear_interp #(
    parameter int MAX_COLS  = 64,
    parameter int MAX_ROWS  = 64,
    parameter int FRAC_BITS = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // row_index[5:0], col_index[11:6], entry_value[43:12],
    // x_coord[75:44], y_coord[107:76], zero fill[111:108]
    input  logic [111:0]                       s_tdata,
    // func[0]
    input  logic                               s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // interp_value[31:0]
    output logic [31:0]                        m_tdata,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [gbi_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [gbi_pkg::COORD_W-1:0]        cfg_data
);

    import gbi_pkg::*;

    localparam int CW         = $clog2(MAX_COLS);
    localparam int RW         = $clog2(MAX_ROWS);
    localparam int HALF_COLS  = (MAX_COLS + 1) / 2;
    localparam int HALF_ROWS  = (MAX_ROWS + 1) / 2;
    localparam int BANK_DEPTH = HALF_COLS * HALF_ROWS;
    localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
    localparam int PRW        = COORD_W + FRAC_BITS + 2;
    localparam logic [FRAC_BITS:0] FRAC_ONE = (FRAC_BITS + 1)'(1) << FRAC_BITS;
    localparam logic signed [PRW:0] HALF = (PRW + 1)'(1) << (FRAC_BITS - 1);

    logic signed [COORD_W-1:0]  x_origin_reg;
    logic signed [COORD_W-1:0]  y_origin_reg;
    logic        [COORD_W-1:0]  x_scale_reg;
    logic        [COORD_W-1:0]  y_scale_reg;
    logic        [GRID_N_W-1:0] grid_cols_reg;
    logic        [GRID_N_W-1:0] grid_rows_reg;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg, out_v_reg;
    logic ld1, ld2, ld3, ld4, ld5, ld6, ld7, ld_out;

    wr_item_t wr_in;
    wr_item_t wr1_reg, wr2_reg, wr3_reg;
    axis_en_t axis_en;

    logic signed [COORD_W-1:0] x_in;
    logic signed [COORD_W-1:0] y_in;
    logic [CW-1:0]             xi3;
    logic [RW-1:0]             yi3;
    logic [FRAC_BITS:0]        xf3;
    logic [FRAC_BITS:0]        yf3;

    logic                      wr_in_range;
    logic                      wr_en;
    logic [1:0]                wr_bank;
    logic [BANK_AW-1:0]        wr_addr;
    logic [COORD_W-1:0]        bank_rdata [4];

    logic                      xp4_reg, yp4_reg;
    logic [FRAC_BITS:0]        xf4_reg, yf4_reg, yf5_reg, yf6_reg;
    logic signed [COORD_W-1:0] a4, b4, c4, d4;
    logic signed [PRW-1:0]     pa5_reg, pb5_reg, pc5_reg, pd5_reg;
    logic signed [PRW:0]       s1_sum, s2_sum, s3_sum;
    logic signed [COORD_W-1:0] z1_6_reg, z2_6_reg;
    logic signed [PRW-1:0]     qa7_reg, qb7_reg;
    logic [COORD_W-1:0]        out_data_reg;

    // Configuration registers.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_origin_reg  <= '0;
            y_origin_reg  <= '0;
            x_scale_reg   <= COORD_W'(65536);
            y_scale_reg   <= COORD_W'(65536);
            grid_cols_reg <= GRID_N_W'(64);
            grid_rows_reg <= GRID_N_W'(64);
        end else if (cfg_valid) begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_X_ORIGIN:  x_origin_reg  <= cfg_data;
                CFG_Y_ORIGIN:  y_origin_reg  <= cfg_data;
                CFG_X_SCALE:   x_scale_reg   <= cfg_data;
                CFG_Y_SCALE:   y_scale_reg   <= cfg_data;
                CFG_GRID_COLS: grid_cols_reg <= cfg_data[GRID_N_W-1:0];
                CFG_GRID_ROWS: grid_rows_reg <= cfg_data[GRID_N_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Per-stage load enables; a stage loads when empty or when it drains.
    assign ld_out   = !out_v_reg || m_tready;
    assign ld7      = !v7_reg || ld_out;
    assign ld6      = !v6_reg || ld7;
    assign ld5      = !v5_reg || ld6;
    assign ld4      = !v4_reg || ld5;
    assign ld3      = !v3_reg || ld4;
    assign ld2      = !v2_reg || ld3;
    assign ld1      = !v1_reg || ld2;
    assign s_tready = ld1;

    assign axis_en.s1 = ld1;
    assign axis_en.s2 = ld2;
    assign axis_en.s3 = ld3;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            v4_reg    <= 1'b0;
            v5_reg    <= 1'b0;
            v6_reg    <= 1'b0;
            v7_reg    <= 1'b0;
            out_v_reg <= 1'b0;
        end else begin
            if (ld1) begin
                v1_reg <= s_tvalid;
            end
            if (ld2) begin
                v2_reg <= v1_reg;
            end
            if (ld3) begin
                v3_reg <= v2_reg;
            end
            if (ld4) begin
                v4_reg <= v3_reg && (wr3_reg.func == FUNC_QUERY);
            end
            if (ld5) begin
                v5_reg <= v4_reg;
            end
            if (ld6) begin
                v6_reg <= v5_reg;
            end
            if (ld7) begin
                v7_reg <= v6_reg;
            end
            if (ld_out) begin
                out_v_reg <= v7_reg;
            end
        end
    end

    // Write fields travel alongside the coordinate mapping.
    assign wr_in.func  = func_t'(s_tuser);
    assign wr_in.row   = s_tdata[5:0];
    assign wr_in.col   = s_tdata[11:6];
    assign wr_in.value = s_tdata[43:12];
    assign x_in        = s_tdata[75:44];
    assign y_in        = s_tdata[107:76];

    always_ff @(posedge aclk) begin
        if (ld1) begin
            wr1_reg <= wr_in;
        end
        if (ld2) begin
            wr2_reg <= wr1_reg;
        end
        if (ld3) begin
            wr3_reg <= wr2_reg;
        end
    end

    gbi_axis #(
        .MAX_N     (MAX_COLS),
        .FRAC_BITS (FRAC_BITS)
    ) u_axis_x (
        .aclk   (aclk),
        .en     (axis_en),
        .coord  (x_in),
        .origin (x_origin_reg),
        .scale  (x_scale_reg),
        .size   (grid_cols_reg),
        .idx    (xi3),
        .frac   (xf3)
    );

    gbi_axis #(
        .MAX_N     (MAX_ROWS),
        .FRAC_BITS (FRAC_BITS)
    ) u_axis_y (
        .aclk   (aclk),
        .en     (axis_en),
        .coord  (y_in),
        .origin (y_origin_reg),
        .scale  (y_scale_reg),
        .size   (grid_rows_reg),
        .idx    (yi3),
        .frac   (yf3)
    );

    // Grid banks, selected by row parity (upper bit) and column parity.
    assign wr_in_range = (32'(wr3_reg.row) < 32'(MAX_ROWS)) &&
                         (32'(wr3_reg.col) < 32'(MAX_COLS));
    assign wr_en   = ld4 && v3_reg && (wr3_reg.func == FUNC_WRITE) && wr_in_range;
    assign wr_bank = {wr3_reg.row[0], wr3_reg.col[0]};
    assign wr_addr = BANK_AW'((32'(wr3_reg.row) >> 1) * 32'(HALF_COLS) +
                              (32'(wr3_reg.col) >> 1));

    for (genvar b = 0; b < 4; b++) begin : g_bank
        logic [RW-1:0]      row_b;
        logic [CW-1:0]      col_b;
        logic [BANK_AW-1:0] rd_addr;

        assign row_b   = (yi3[0] == 1'(b >> 1)) ? yi3 : yi3 + RW'(1);
        assign col_b   = (xi3[0] == 1'(b)) ? xi3 : xi3 + CW'(1);
        assign rd_addr = BANK_AW'((32'(row_b) >> 1) * 32'(HALF_COLS) +
                                  (32'(col_b) >> 1));

        gbi_ram #(
            .DATA_W (COORD_W),
            .DEPTH  (BANK_DEPTH),
            .ADDR_W (BANK_AW)
        ) u_ram (
            .aclk  (aclk),
            .we    (wr_en && (wr_bank == 2'(b))),
            .waddr (wr_addr),
            .wdata (wr3_reg.value),
            .re    (ld4),
            .raddr (rd_addr),
            .rdata (bank_rdata[b])
        );
    end

    always_ff @(posedge aclk) begin
        if (ld4) begin
            xp4_reg <= xi3[0];
            yp4_reg <= yi3[0];
            xf4_reg <= xf3;
            yf4_reg <= yf3;
        end
    end

    // Blend along x: products, then rounded sums.
    assign a4 = bank_rdata[{yp4_reg, xp4_reg}];
    assign b4 = bank_rdata[{yp4_reg, !xp4_reg}];
    assign c4 = bank_rdata[{!yp4_reg, xp4_reg}];
    assign d4 = bank_rdata[{!yp4_reg, !xp4_reg}];

    always_ff @(posedge aclk) begin
        if (ld5) begin
            pa5_reg <= a4 * $signed({1'b0, FRAC_ONE - xf4_reg});
            pb5_reg <= b4 * $signed({1'b0, xf4_reg});
            pc5_reg <= c4 * $signed({1'b0, FRAC_ONE - xf4_reg});
            pd5_reg <= d4 * $signed({1'b0, xf4_reg});
            yf5_reg <= yf4_reg;
        end
    end

    assign s1_sum = {pa5_reg[PRW-1], pa5_reg} + {pb5_reg[PRW-1], pb5_reg} + HALF;
    assign s2_sum = {pc5_reg[PRW-1], pc5_reg} + {pd5_reg[PRW-1], pd5_reg} + HALF;

    always_ff @(posedge aclk) begin
        if (ld6) begin
            z1_6_reg <= s1_sum[FRAC_BITS+COORD_W-1:FRAC_BITS];
            z2_6_reg <= s2_sum[FRAC_BITS+COORD_W-1:FRAC_BITS];
            yf6_reg  <= yf5_reg;
        end
    end

    // Blend along y.
    always_ff @(posedge aclk) begin
        if (ld7) begin
            qa7_reg <= z1_6_reg * $signed({1'b0, FRAC_ONE - yf6_reg});
            qb7_reg <= z2_6_reg * $signed({1'b0, yf6_reg});
        end
    end

    assign s3_sum = {qa7_reg[PRW-1], qa7_reg} + {qb7_reg[PRW-1], qb7_reg} + HALF;

    always_ff @(posedge aclk) begin
        if (ld_out) begin
            out_data_reg <= s3_sum[FRAC_BITS+COORD_W-1:FRAC_BITS];
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ----- verif/tb_grid_bilinear_interp.sv -----
// ---------------------------------------------------------------------------
// tb_grid_bilinear_interp
// Self-checking testbench for the bilinear grid lookup block.
// ---------------------------------------------------------------------------
// A short table of directed beats runs under the reset settings first. Then
// the settings are reloaded several times, extremes among them, and random
// write and query beats follow. Before each query, any of its four
// neighbours that has never been written is written first. Every query
// result is predicted from a local copy of the grid and settings, or taken
// from the table for typed directed beats, and checked in order. The sender
// pauses between bursts and the receiver stalls on a pattern of its own.
// ---------------------------------------------------------------------------
module tb_grid_bilinear_interp;
    import gbi_pkg::*;

    localparam int IDLE_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 16;

    logic          aclk      = 1'b0;
    logic          aresetn   = 1'b0;
    logic          s_tvalid  = 1'b0;
    logic          s_tready;
    logic [111:0]  s_tdata   = '0;
    logic          s_tuser   = 1'b0;
    logic          m_tvalid;
    logic          m_tready  = 1'b0;
    logic [31:0]   m_tdata;
    logic          cfg_valid = 1'b0;
    logic          cfg_ready;
    logic [2:0]    cfg_index = '0;
    logic [31:0]   cfg_data  = '0;

    typedef struct {
        func_t       func;
        logic [5:0]  row;
        logic [5:0]  col;
        logic [31:0] value;
        logic [31:0] x;
        logic [31:0] y;
        bit          typed;
        logic [31:0] want;
    } beat_vec_t;

    logic [31:0] grid_copy [64][64];
    bit          written   [64][64];
    logic [31:0] x_org  = 32'd0;
    logic [31:0] y_org  = 32'd0;
    logic [31:0] x_scl  = 32'h0001_0000;
    logic [31:0] y_scl  = 32'h0001_0000;
    logic [6:0]  n_cols = 7'd64;
    logic [6:0]  n_rows = 7'd64;

    logic [31:0] pending_values [$];
    logic [31:0] want_value;
    int          errors = 0;
    int          idle_cycles = 0;
    int          burst_left = 0;
    bit          steady = 1'b0;
    logic [31:0] tick = '0;
    logic [15:0] ready_pat = 16'hFFFF;

    beat_vec_t dir_vecs [0:14] = '{
        '{FUNC_WRITE,  6'd0,  6'd0, 32'h7FFF_FFFF, 32'h0, 32'h0, 1'b0, 32'h0},
        '{FUNC_WRITE,  6'd0,  6'd1, 32'h8000_0000, 32'h0, 32'h0, 1'b0, 32'h0},
        '{FUNC_WRITE,  6'd1,  6'd0, 32'h0000_0000, 32'h0, 32'h0, 1'b0, 32'h0},
        '{FUNC_WRITE,  6'd1,  6'd1, 32'h0001_0000, 32'h0, 32'h0, 1'b0, 32'h0},
        '{FUNC_QUERY,  6'd0,  6'd0, 32'h0, 32'h0000_0000, 32'h0000_0000,
          1'b1, 32'h7FFF_FFFF},
        '{FUNC_QUERY,  6'd0,  6'd0, 32'h0, 32'h8000_0000, 32'h8000_0000,
          1'b1, 32'h7FFF_FFFF},
        '{FUNC_QUERY,  6'd0,  6'd0, 32'h0, 32'h0000_8000, 32'h0000_0000,
          1'b0, 32'h0},
        '{FUNC_QUERY,  6'd0,  6'd0, 32'h0, 32'h0000_8000, 32'h0000_8000,
          1'b0, 32'h0},
        '{FUNC_WRITE, 6'd62, 6'd62, 32'h8000_0000, 32'h0, 32'h0, 1'b0, 32'h0},
        '{FUNC_WRITE, 6'd62, 6'd63, 32'h7FFF_FFFF, 32'h0, 32'h0, 1'b0, 32'h0},
        '{FUNC_WRITE, 6'd63, 6'd62, 32'hFFFF_FFFF, 32'h0, 32'h0, 1'b0, 32'h0},
        '{FUNC_WRITE, 6'd63, 6'd63, 32'h1234_5678, 32'h0, 32'h0, 1'b0, 32'h0},
        '{FUNC_QUERY,  6'd0,  6'd0, 32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
          1'b1, 32'h1234_5678},
        '{FUNC_QUERY,  6'd0,  6'd0, 32'h0, 32'h003F_0000, 32'h003F_0000,
          1'b1, 32'h1234_5678},
        '{FUNC_QUERY,  6'd0,  6'd0, 32'h0, 32'h003E_FFFF, 32'h003E_FFFF,
          1'b0, 32'h0}
    };

    grid_bilinear_interp dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 aclk = ~aclk;

    function automatic int eff_size(input logic [6:0] n);
        if (n < 7'd2) return 2;
        if (n > 7'd64) return 64;
        return int'(n);
    endfunction

    function automatic void locate(input logic [31:0] coord, input logic [31:0] org,
                                   input logic [31:0] scl, input int n,
                                   output int idx, output longint frac);
        longint      d;
        logic [95:0] pos;
        logic [95:0] lim;
        d = longint'($signed(coord)) - longint'($signed(org));
        lim = 96'(n - 1) << 16;
        pos = '0;
        if (d > 0) begin
            pos = (96'(d) * {64'd0, scl}) >> 16;
            if (pos > lim) pos = lim;
        end
        if (pos >= lim) begin
            idx = n - 2;
            frac = 64'd65536;
        end else begin
            idx = int'(pos >> 16);
            frac = {48'd0, pos[15:0]};
        end
    endfunction

    function automatic longint mix(input longint a, input longint b, input longint f);
        longint s;
        s = a * (64'd65536 - f) + b * f + 64'd32768;
        return s >>> 16;
    endfunction

    function automatic logic [31:0] interp_at(input logic [31:0] x, input logic [31:0] y);
        int     xi;
        int     yi;
        longint xf;
        longint yf;
        longint upper;
        longint lower;
        locate(x, x_org, x_scl, eff_size(n_cols), xi, xf);
        locate(y, y_org, y_scl, eff_size(n_rows), yi, yf);
        upper = mix(longint'($signed(grid_copy[yi][xi])),
                    longint'($signed(grid_copy[yi][xi + 1])), xf);
        lower = mix(longint'($signed(grid_copy[yi + 1][xi])),
                    longint'($signed(grid_copy[yi + 1][xi + 1])), xf);
        return 32'(mix(upper, lower, yf));
    endfunction

    function automatic logic [31:0] sample_value();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_coord(input logic [31:0] org, input logic [31:0] scl,
                                               input int n);
        longint p;
        longint d;
        if (scl == 32'd0 || $urandom_range(0, 4) == 0) return $urandom;
        p = longint'($urandom_range(0, (n + 1) * 65536)) - 64'd16384;
        if ($urandom_range(0, 3) == 0) p = p & ~64'hFFFF;
        d = (p <<< 16) / longint'({32'd0, scl});
        return org + 32'(d);
    endfunction

    task automatic send_beat(input func_t f, input logic [5:0] r, input logic [5:0] c,
                             input logic [31:0] v, input logic [31:0] x,
                             input logic [31:0] y, input bit typed,
                             input logic [31:0] want);
        int gap;
        if (burst_left == 0) begin
            gap = (steady || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 20);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= f;
        s_tdata  <= {4'b0, y, x, v, c, r};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        burst_left--;
        if (f == FUNC_WRITE) begin
            grid_copy[r][c] = v;
            written[r][c] = 1'b1;
        end else begin
            pending_values.push_back(typed ? want : interp_at(x, y));
        end
    endtask

    task automatic random_query();
        logic [31:0] x;
        logic [31:0] y;
        int          xi;
        int          yi;
        longint      xf;
        longint      yf;
        x = pick_coord(x_org, x_scl, eff_size(n_cols));
        y = pick_coord(y_org, y_scl, eff_size(n_rows));
        locate(x, x_org, x_scl, eff_size(n_cols), xi, xf);
        locate(y, y_org, y_scl, eff_size(n_rows), yi, yf);
        for (int r = 0; r < 2; r++) begin
            for (int c = 0; c < 2; c++) begin
                if (!written[yi + r][xi + c]) begin
                    send_beat(FUNC_WRITE, 6'(yi + r), 6'(xi + c), sample_value(),
                              $urandom, $urandom, 1'b0, 32'h0);
                end
            end
        end
        send_beat(FUNC_QUERY, 6'($urandom), 6'($urandom), $urandom, x, y, 1'b0, 32'h0);
    endtask

    task automatic settle_pipeline();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_values.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic put_reg(input cfg_reg_t idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            CFG_X_ORIGIN:  x_org = data;
            CFG_Y_ORIGIN:  y_org = data;
            CFG_X_SCALE:   x_scl = data;
            CFG_Y_SCALE:   y_scl = data;
            CFG_GRID_COLS: n_cols = data[6:0];
            CFG_GRID_ROWS: n_rows = data[6:0];
            default: ;
        endcase
    endtask

    task automatic load_settings(input logic [31:0] xo, input logic [31:0] yo,
                                 input logic [31:0] xs, input logic [31:0] ys,
                                 input logic [6:0] nc, input logic [6:0] nr);
        put_reg(CFG_X_ORIGIN, xo);
        put_reg(CFG_Y_ORIGIN, yo);
        put_reg(CFG_X_SCALE, xs);
        put_reg(CFG_Y_SCALE, ys);
        put_reg(CFG_GRID_COLS, {25'd0, nc});
        put_reg(CFG_GRID_ROWS, {25'd0, nr});
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] random_origin();
        if ($urandom_range(0, 2) == 0) return $urandom;
        return 32'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
    endfunction

    function automatic logic [6:0] random_size();
        if ($urandom_range(0, 9) == 0) return 7'($urandom_range(0, 127));
        return 7'($urandom_range(2, 64));
    endfunction

    always @(posedge aclk) begin
        tick <= tick + 1;
        if (tick[5:0] == 6'd0) begin
            ready_pat <= ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                                     : (16'($urandom) | 16'h0001);
        end
        m_tready <= ready_pat[tick[3:0]];
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_values.size() == 0) begin
                $display("%0t: result beat with none expected, actual %h", $time, m_tdata);
                errors++;
            end else begin
                want_value = pending_values.pop_front();
                if (m_tdata !== want_value) begin
                    $display("%0t: interp_value mismatch, expected %h, actual %h",
                             $time, want_value, m_tdata);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < $size(dir_vecs); i++) begin
            send_beat(dir_vecs[i].func, dir_vecs[i].row, dir_vecs[i].col, dir_vecs[i].value,
                      dir_vecs[i].x, dir_vecs[i].y, dir_vecs[i].typed, dir_vecs[i].want);
        end

        for (int ph = 0; ph < 10; ph++) begin
            settle_pipeline();
            case (ph)
                0: load_settings(32'h0, 32'h0, 32'h0, 32'h0, 7'd0, 7'd1);
                1: load_settings(32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF,
                                 32'hFFFF_FFFF, 7'd127, 7'd65);
                2: load_settings(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0001_0000,
                                 32'h0001_0000, 7'd64, 7'd2);
                3: load_settings(random_origin(), random_origin(), 32'h0001_0000,
                                 32'h0001_0000, 7'd2, 7'd64);
                default: load_settings(random_origin(), random_origin(),
                                       $urandom_range(32'h2000, 32'h0008_0000),
                                       $urandom_range(32'h2000, 32'h0008_0000),
                                       random_size(), random_size());
            endcase
            steady = (ph % 3 == 2);
            for (int k = 0; k < 100; k++) begin
                if ($urandom_range(0, 3) == 0) begin
                    send_beat(FUNC_WRITE, 6'($urandom), 6'($urandom), sample_value(),
                              $urandom, $urandom, 1'b0, 32'h0);
                end else begin
                    random_query();
                end
            end
        end

        settle_pipeline();
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
